FILE: hdl/frte_pkg.sv
// Shared types, codes and helpers for the fixed record table engine.
package frte_pkg;

    // Fixed field widths of the item interfaces
    localparam int DATA_W    = 64;
    localparam int KIND_W    = 2;
    localparam int SIZE_W    = 4;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SIZE     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_GETW  = 6'b000100,
        S_FIND  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_REPLY = 6'b100000
    } frte_state_t;

    // Read address selection for the record memory
    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_POS  = 3'd1,
        RD_POS1 = 3'd2,
        RD_ZERO = 3'd3,
        RD_NEXT = 3'd4
    } frte_rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic                req_load;
        logic                append_commit;
        logic                status_load;
        logic [STATUS_W-1:0] status_code;
        frte_rd_sel_t        rd_sel;
        logic                shift_write;
        logic                count_dec;
        logic                get_capture;
        logic                found_capture;
        logic                out_load;
    } frte_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              size_bad;
        logic              size_mismatch;
        logic              full;
        logic              pos_bad;
        logic              del_last;
        logic              count_zero;
        logic              key_match;
        logic              scan_last;
        logic              out_free;
    } frte_sts_t;

    // Mask that keeps the low nbytes bytes of a record
    function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < nbytes) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

FILE: hdl/frte_ctrl.sv
// Request sequencer of the fixed record table engine.
module frte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  frte_pkg::frte_sts_t sts,
    output frte_pkg::frte_cmd_t cmd
);
    import frte_pkg::*;

    frte_state_t state_reg;
    frte_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                state_next = S_REPLY;
                unique case (sts.kind)
                    KIND_APPEND:
                    begin
                        if (sts.size_bad || sts.size_mismatch)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = STAT_SIZE;
                        end
                        else if (sts.full)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.append_commit = 1'b1;
                        end
                    end
                    KIND_GET:
                    begin
                        if (sts.pos_bad)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = STAT_RANGE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_POS;
                            state_next = S_GETW;
                        end
                    end
                    KIND_FIND:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = STAT_NOTFOUND;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_ZERO;
                            state_next = S_FIND;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (sts.pos_bad)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = STAT_RANGE;
                        end
                        else if (sts.del_last)
                        begin
                            cmd.count_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_POS1;
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_GETW:
            begin
                cmd.get_capture = 1'b1;
                state_next      = S_REPLY;
            end
            S_FIND:
            begin
                // Compare one stored record per cycle, stop at the first hit
                if (sts.key_match)
                begin
                    cmd.found_capture = 1'b1;
                    state_next        = S_REPLY;
                end
                else if (sts.scan_last)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_code = STAT_NOTFOUND;
                    state_next      = S_REPLY;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_SHIFT:
            begin
                // Move one record down per cycle
                cmd.shift_write = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_REPLY;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/frte_dpath.sv
// Record memory, table registers, compare logic and result register.
module frte_dpath #(
    parameter int CAPACITY         = 64,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [frte_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [frte_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [frte_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [frte_pkg::STATUS_W-1:0]    m_tuser,
    input  frte_pkg::frte_cmd_t              cmd,
    output frte_pkg::frte_sts_t              sts
);
    import frte_pkg::*;

    localparam int REC_W = 8 * MAX_RECORD_BYTES;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int XW    = (CW > POS_W) ? CW : POS_W;

    // Request fields
    logic [KIND_W-1:0] req_kind_reg;
    logic [DATA_W-1:0] req_data_reg;
    logic [SIZE_W-1:0] req_size_reg;
    logic [POS_W-1:0]  req_pos_reg;

    // Table state
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [SIZE_W-1:0] rec_size_reg;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     ptr_next;

    // Record memory
    logic [REC_W-1:0]  mem [CAPACITY];
    logic [REC_W-1:0]  mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [REC_W-1:0]  mem_wdata;
    logic              mem_re;

    // Result being built and the output stage
    logic [STATUS_W-1:0] res_status_reg;
    logic [DATA_W-1:0]   res_data_reg;
    logic [POS_W-1:0]    res_fpos_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [POS_W-1:0]    out_fpos_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [DATA_W-1:0] rdata_ext;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] app_data;
    logic [XW-1:0]     pos_ext;
    logic [XW-1:0]     count_ext;
    logic [CW-1:0]     ptr_inc;

    assign rdata_ext = DATA_W'(mem_rdata_reg);
    assign key       = req_data_reg & byte_mask(rec_size_reg);
    assign app_data  = req_data_reg & byte_mask(req_size_reg);
    assign pos_ext   = XW'(req_pos_reg);
    assign count_ext = XW'(count_reg);
    assign ptr_inc   = ptr_reg + CW'(1);

    // Status toward the controller
    always_comb
    begin
        sts               = '0;
        sts.kind          = req_kind_reg;
        sts.size_bad      = (req_size_reg == '0) || (req_size_reg > SIZE_W'(MAX_RECORD_BYTES));
        sts.size_mismatch = (count_reg != '0) && (req_size_reg != rec_size_reg);
        sts.full          = (count_reg == CW'(CAPACITY));
        sts.pos_bad       = (pos_ext >= count_ext);
        sts.del_last      = ((pos_ext + XW'(1)) == count_ext);
        sts.count_zero    = (count_reg == '0);
        sts.key_match     = (rdata_ext == key);
        sts.scan_last     = (ptr_inc == count_reg);
        sts.out_free      = !out_valid_reg || m_tready;
    end

    // Read pointer and memory port selection
    always_comb
    begin
        ptr_next = ptr_reg;
        mem_re   = 1'b1;
        case (cmd.rd_sel)
            RD_POS:  ptr_next = CW'(req_pos_reg);
            RD_POS1: ptr_next = CW'(req_pos_reg) + CW'(1);
            RD_ZERO: ptr_next = '0;
            RD_NEXT: ptr_next = ptr_inc;
            default: mem_re   = 1'b0;
        endcase

        mem_we    = cmd.append_commit || cmd.shift_write;
        mem_waddr = cmd.shift_write ? AW'(ptr_reg - CW'(1)) : AW'(count_reg);
        mem_wdata = cmd.shift_write ? mem_rdata_reg : REC_W'(app_data);

        count_next = count_reg;
        if (cmd.append_commit)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Record memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[AW'(ptr_next)];
        end
    end

    // Capture request and build the result
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.req_load)
        begin
            req_kind_reg   <= s_tuser;
            req_data_reg   <= s_tdata[DATA_W-1:0];
            req_size_reg   <= s_tdata[DATA_W +: SIZE_W];
            req_pos_reg    <= s_tdata[DATA_W + SIZE_W +: POS_W];
            res_status_reg <= STAT_OK;
            res_data_reg   <= '0;
            res_fpos_reg   <= '0;
        end
        else
        begin
            if (cmd.status_load)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.get_capture)
            begin
                res_data_reg <= rdata_ext;
            end
            if (cmd.found_capture)
            begin
                res_fpos_reg <= POS_W'(ptr_reg);
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_fpos_reg   <= res_fpos_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    // Table control registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rec_size_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.append_commit && (count_reg == '0))
            begin
                rec_size_reg <= req_size_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_fpos_reg, out_data_reg};

endmodule

FILE: hdl/fixed_record_table_engine_unit.sv
// Top level of the fixed record table engine: controller, datapath and checks.
//
// Usage: each request item on the s_ side (kind in s_tuser) produces exactly one
// result item on the m_ side (status in m_tuser). Append adds a record of
// 1..MAX_RECORD_BYTES bytes at the end, get reads a position, find returns the
// lowest matching position, delete removes a position and closes the gap.
// Append, rejected requests and a delete of the last record go from the start
// step to the reply step; get adds a read step, find scans from position 0 to
// the first hit or the last record and delete moves each later record down.
// Find and delete go through the record memory one record per cycle. The block
// works on one item at a time; s_tready is high only while it waits for a
// request.
// Results sit in an output register: the next request is accepted while a
// result waits, and a stalled receiver only holds the engine at its reply
// step. Reset empties the table (count and record size go to zero) and drops
// any pending result; memory contents are not cleared.
module fixed_record_table_engine_unit #(
    parameter int CAPACITY         = 64,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_data[63:0], size_bytes[67:64], position[73:68], zero fill
    input  logic [frte_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [frte_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[63:0], found_position[69:64], entry_count[76:70], zero fill
    output logic [frte_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [frte_pkg::STATUS_W-1:0]    m_tuser
);
    import frte_pkg::*;

    frte_cmd_t cmd;
    frte_sts_t sts;

    frte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frte_dpath #(
        .CAPACITY         (CAPACITY),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Never overwrite a result that the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while stalled");

    // One item at a time: no second accept right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Never append into a full table
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append_commit |-> !sts.full)
        else $error("append committed into a full table");

endmodule
